/* sv/pds_pkg.sv */
// Shared types, tables and constants of the PLL divider select unit.
`timescale 1ns / 1ps
package pds_pkg;

    localparam int FREQ_W = 16;
    localparam int NUM_W  = 32;   // f * ref_divider
    localparam int THR_W  = 28;   // threshold * 8 * 2 * ref_freq
    localparam int X_W    = 26;   // rounding dividend, below 256 * divisor when not clipped
    localparam int DEN_W  = 17;   // 2 * ref_freq
    localparam int D1_W   = 18;   // 4 * ref_freq
    localparam int N_W    = 8;
    localparam int PD_W   = 4;
    localparam int A_W    = 25;   // 2 * ref_freq * N
    localparam int B_W    = 20;   // ref_divider * post divider
    localparam int NSEL   = 7;

    // quotient bits retired per pipeline stage in each divider
    localparam int D1_STEPS  = 2;
    localparam int D1_STAGES = N_W / D1_STEPS;
    localparam int D2_STEPS  = 2;
    localparam int D2_STAGES = FREQ_W / D2_STEPS;

    localparam logic [1:0] REG_MIN_FREQ    = 2'd0;
    localparam logic [1:0] REG_MAX_FREQ    = 2'd1;
    localparam logic [1:0] REG_REF_FREQ    = 2'd2;
    localparam logic [1:0] REG_REF_DIVIDER = 2'd3;

    typedef enum logic [1:0] {
        PCODE_DIV1 = 2'd0,
        PCODE_DIV2 = 2'd1,
        PCODE_DIV4 = 2'd2,
        PCODE_DIV8 = 2'd3
    } pcode_t;

    // ratio thresholds times 8: 255, 127.5, 85, 63.75, 42.5, 31.875, 21.25
    localparam logic [11:0] THR8 [NSEL] = '{12'd2040, 12'd1020, 12'd680, 12'd510,
                                            12'd340, 12'd255, 12'd170};
    localparam logic [PD_W-1:0] PDIV_TAB [NSEL] = '{4'd1, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8};
    localparam pcode_t PCODE_TAB [NSEL] = '{PCODE_DIV1, PCODE_DIV1, PCODE_DIV2, PCODE_DIV1,
                                           PCODE_DIV4, PCODE_DIV4, PCODE_DIV8};
    localparam logic EXT_TAB [NSEL] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

    typedef struct packed {
        logic [FREQ_W-1:0] min_freq;
        logic [FREQ_W-1:0] max_freq;
        logic [FREQ_W-1:0] ref_freq;     // zero already mapped to one
        logic [FREQ_W-1:0] ref_divider;  // zero already mapped to one
    } cfg_t;

    typedef struct packed {
        logic            clipped;
        pcode_t          code;
        logic            ext;
        logic [PD_W-1:0] pd;
    } sel_t;

    typedef struct packed {
        logic [N_W-1:0] n;
        sel_t           sel;
        logic           sat;
    } side2_t;

endpackage

/* sv/pds_divstep.sv */
// One pipeline stage of a restoring divider, retiring NS quotient bits.
`timescale 1ns / 1ps
module pds_divstep #(
    parameter int RW = 26,
    parameter int DW = 18,
    parameter int QW = 8,
    parameter int HI = 7,
    parameter int NS = 2,
    parameter int SW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [RW-1:0] in_rem,
    input  logic [QW-1:0] in_quo,
    input  logic [DW-1:0] in_dvs,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [RW-1:0] out_rem,
    output logic [QW-1:0] out_quo,
    output logic [DW-1:0] out_dvs,
    output logic [SW-1:0] out_side
);

    logic          valid_reg;
    logic [RW-1:0] rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [DW-1:0] dvs_reg;
    logic [SW-1:0] side_reg;

    always_comb begin
        rem_next = in_rem;
        quo_next = in_quo;
        for (int j = 0; j < NS; j++) begin
            if ((rem_next >> (HI - j)) >= RW'(in_dvs)) begin
                rem_next = rem_next - (RW'(in_dvs) << (HI - j));
                quo_next[HI - j] = 1'b1;
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dvs_reg  <= in_dvs;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_dvs   = dvs_reg;
    assign out_side  = side_reg;

endmodule

/* sv/pds_front.sv */
// Front stages: clamp, ratio product, post divider select, rounding dividend.
`timescale 1ns / 1ps
module pds_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  pds_pkg::cfg_t                    cfg,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [pds_pkg::FREQ_W-1:0]       in_freq,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [pds_pkg::X_W-1:0]          out_x,
    output logic [pds_pkg::D1_W-1:0]         out_d,
    output pds_pkg::sel_t                    out_sel
);

    logic [3:0] vld_reg;
    logic [3:0] en;

    logic [pds_pkg::FREQ_W-1:0] f_next, f_reg;
    logic [pds_pkg::NUM_W-1:0]  num_reg, num3_reg;
    logic [pds_pkg::THR_W-1:0]  thr_reg [pds_pkg::NSEL];
    logic [pds_pkg::NSEL-1:0]   gt;
    pds_pkg::sel_t              sel_next, sel_reg, sel4_reg;
    logic [pds_pkg::DEN_W-1:0]  den;
    logic [29:0]                prod;
    logic [pds_pkg::X_W-1:0]    x_next, x_reg;

    assign en[3]    = !vld_reg[3] || out_ready;
    assign en[2]    = !vld_reg[2] || en[3];
    assign en[1]    = !vld_reg[1] || en[2];
    assign en[0]    = !vld_reg[0] || en[1];
    assign in_ready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) vld_reg[0] <= in_valid;
            if (en[1]) vld_reg[1] <= vld_reg[0];
            if (en[2]) vld_reg[2] <= vld_reg[1];
            if (en[3]) vld_reg[3] <= vld_reg[2];
        end
    end

    // min first, then max: max wins when the limits cross
    always_comb begin
        f_next = in_freq;
        if (f_next < cfg.min_freq) f_next = cfg.min_freq;
        if (f_next > cfg.max_freq) f_next = cfg.max_freq;
    end

    assign den = {cfg.ref_freq, 1'b0};

    // thresholds scaled by the denominator, follow the config registers
    always_ff @(posedge aclk) begin
        for (int i = 0; i < pds_pkg::NSEL; i++) begin
            thr_reg[i] <= pds_pkg::THR_W'(pds_pkg::THR_W'(pds_pkg::THR8[i])
                                          * pds_pkg::THR_W'(den));
        end
    end

    always_comb begin
        for (int i = 0; i < pds_pkg::NSEL; i++) begin
            gt[i] = {num_reg, 3'b000} > 35'(thr_reg[i]);
        end
        sel_next.clipped = 1'b0;
        sel_next.code    = pds_pkg::PCODE_DIV8;
        sel_next.ext     = 1'b1;
        sel_next.pd      = 4'd12;
        // lowest index that fires wins
        for (int i = pds_pkg::NSEL - 1; i >= 0; i--) begin
            if (gt[i]) begin
                sel_next.code = pds_pkg::PCODE_TAB[i];
                sel_next.ext  = pds_pkg::EXT_TAB[i];
                sel_next.pd   = pds_pkg::PDIV_TAB[i];
            end
        end
        sel_next.clipped = gt[0];
    end

    // 2*num*pd + den; num stays below 2^25 whenever the ratio is not clipped
    assign prod   = 30'(num3_reg[24:0]) * 30'(sel_reg.pd);
    assign x_next = pds_pkg::X_W'((prod << 1) + 30'(den));

    always_ff @(posedge aclk) begin
        if (en[0]) f_reg <= f_next;
        if (en[1]) num_reg <= pds_pkg::NUM_W'(f_reg) * pds_pkg::NUM_W'(cfg.ref_divider);
        if (en[2]) begin
            num3_reg <= num_reg;
            sel_reg  <= sel_next;
        end
        if (en[3]) begin
            x_reg    <= x_next;
            sel4_reg <= sel_reg;
        end
    end

    assign out_valid = vld_reg[3];
    assign out_x     = x_reg;
    assign out_d     = {cfg.ref_freq, 2'b00};
    assign out_sel   = sel4_reg;

endmodule

/* sv/pds_mid.sv */
// Middle stages: clip N, form the frequency dividend and divisor, detect saturation.
`timescale 1ns / 1ps
module pds_mid (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  pds_pkg::cfg_t              cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [pds_pkg::N_W-1:0]    in_quo,
    input  pds_pkg::sel_t              in_sel,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [pds_pkg::A_W-1:0]    out_num,
    output logic [pds_pkg::B_W-1:0]    out_div,
    output pds_pkg::side2_t            out_side
);

    logic [1:0] vld_reg;
    logic [1:0] en;

    logic [pds_pkg::N_W-1:0] n;
    logic [pds_pkg::A_W-1:0] num_reg, num2_reg;
    logic [pds_pkg::B_W-1:0] div_reg, div2_reg;
    pds_pkg::side2_t         side_reg, side2_reg, side_next;

    assign en[1]    = !vld_reg[1] || out_ready;
    assign en[0]    = !vld_reg[0] || en[1];
    assign in_ready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) vld_reg[0] <= in_valid;
            if (en[1]) vld_reg[1] <= vld_reg[0];
        end
    end

    assign n = in_sel.clipped ? '1 : in_quo;

    // quotient saturates exactly when num >= div * 2^16
    always_comb begin
        side_next     = side_reg;
        side_next.sat = pds_pkg::B_W'(num_reg[pds_pkg::A_W-1:pds_pkg::FREQ_W]) >= div_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            num_reg      <= pds_pkg::A_W'(pds_pkg::A_W'({cfg.ref_freq, 1'b0})
                                          * pds_pkg::A_W'(n));
            div_reg      <= pds_pkg::B_W'(pds_pkg::B_W'(cfg.ref_divider)
                                          * pds_pkg::B_W'(in_sel.pd));
            side_reg.n   <= n;
            side_reg.sel <= in_sel;
            side_reg.sat <= 1'b0;
        end
        if (en[1]) begin
            num2_reg  <= num_reg;
            div2_reg  <= div_reg;
            side2_reg <= side_next;
        end
    end

    assign out_valid = vld_reg[1];
    assign out_num   = num2_reg;
    assign out_div   = div2_reg;
    assign out_side  = side2_reg;

endmodule

/* sv/pll_divider_select_unit.sv */
// Top level of the PLL divider select unit: config registers, pipeline, output register.
`timescale 1ns / 1ps
// Depth: 19 register stages.
// Throughput: one item per cycle when not stalled; each divider retires two
// quotient bits per stage (4 stages for feedback divider, 8 for achieved frequency).
// Stalls are absorbed stage by stage, so bubbles collapse while the output waits.
// Reset (aresetn, synchronous) empties the pipeline and loads the register defaults.
module pll_divider_select_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_target_freq,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_feedback_divider,
    output logic [1:0]  m_post_div_code,
    output logic        m_external_div,
    output logic [15:0] m_actual_freq,
    output logic        m_ratio_clipped
);

    localparam int ND1 = pds_pkg::D1_STAGES;
    localparam int ND2 = pds_pkg::D2_STAGES;

    logic [15:0] min_freq_reg, max_freq_reg, ref_freq_reg, ref_divider_reg;
    pds_pkg::cfg_t cfg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_freq_reg    <= 16'd0;
            max_freq_reg    <= 16'd65535;
            ref_freq_reg    <= 16'd1432;
            ref_divider_reg <= 16'd33;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                pds_pkg::REG_MIN_FREQ:    min_freq_reg    <= cfg_wdata;
                pds_pkg::REG_MAX_FREQ:    max_freq_reg    <= cfg_wdata;
                pds_pkg::REG_REF_FREQ:    ref_freq_reg    <= cfg_wdata;
                pds_pkg::REG_REF_DIVIDER: ref_divider_reg <= cfg_wdata;
            endcase
        end
    end

    assign cfg.min_freq    = min_freq_reg;
    assign cfg.max_freq    = max_freq_reg;
    assign cfg.ref_freq    = (ref_freq_reg == '0) ? 16'd1 : ref_freq_reg;
    assign cfg.ref_divider = (ref_divider_reg == '0) ? 16'd1 : ref_divider_reg;

    // feedback divider chain
    logic                          d1_valid [ND1+1];
    logic                          d1_ready [ND1+1];
    logic [pds_pkg::X_W-1:0]       d1_rem   [ND1+1];
    logic [pds_pkg::N_W-1:0]       d1_quo   [ND1+1];
    logic [pds_pkg::D1_W-1:0]      d1_dvs   [ND1+1];
    pds_pkg::sel_t                 d1_side  [ND1+1];

    pds_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_freq   (s_target_freq),
        .out_valid (d1_valid[0]),
        .out_ready (d1_ready[0]),
        .out_x     (d1_rem[0]),
        .out_d     (d1_dvs[0]),
        .out_sel   (d1_side[0])
    );
    assign d1_quo[0] = '0;

    for (genvar i = 0; i < ND1; i++) begin : g_div1
        pds_divstep #(
            .RW (pds_pkg::X_W),
            .DW (pds_pkg::D1_W),
            .QW (pds_pkg::N_W),
            .HI (pds_pkg::N_W - 1 - i * pds_pkg::D1_STEPS),
            .NS (pds_pkg::D1_STEPS),
            .SW ($bits(pds_pkg::sel_t))
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (d1_valid[i]),
            .in_ready  (d1_ready[i]),
            .in_rem    (d1_rem[i]),
            .in_quo    (d1_quo[i]),
            .in_dvs    (d1_dvs[i]),
            .in_side   (d1_side[i]),
            .out_valid (d1_valid[i+1]),
            .out_ready (d1_ready[i+1]),
            .out_rem   (d1_rem[i+1]),
            .out_quo   (d1_quo[i+1]),
            .out_dvs   (d1_dvs[i+1]),
            .out_side  (d1_side[i+1])
        );
    end

    // achieved frequency chain
    logic                          d2_valid [ND2+1];
    logic                          d2_ready [ND2+1];
    logic [pds_pkg::A_W-1:0]       d2_rem   [ND2+1];
    logic [pds_pkg::FREQ_W-1:0]    d2_quo   [ND2+1];
    logic [pds_pkg::B_W-1:0]       d2_dvs   [ND2+1];
    pds_pkg::side2_t               d2_side  [ND2+1];

    pds_mid u_mid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (d1_valid[ND1]),
        .in_ready  (d1_ready[ND1]),
        .in_quo    (d1_quo[ND1]),
        .in_sel    (d1_side[ND1]),
        .out_valid (d2_valid[0]),
        .out_ready (d2_ready[0]),
        .out_num   (d2_rem[0]),
        .out_div   (d2_dvs[0]),
        .out_side  (d2_side[0])
    );
    assign d2_quo[0] = '0;

    for (genvar i = 0; i < ND2; i++) begin : g_div2
        pds_divstep #(
            .RW (pds_pkg::A_W),
            .DW (pds_pkg::B_W),
            .QW (pds_pkg::FREQ_W),
            .HI (pds_pkg::FREQ_W - 1 - i * pds_pkg::D2_STEPS),
            .NS (pds_pkg::D2_STEPS),
            .SW ($bits(pds_pkg::side2_t))
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (d2_valid[i]),
            .in_ready  (d2_ready[i]),
            .in_rem    (d2_rem[i]),
            .in_quo    (d2_quo[i]),
            .in_dvs    (d2_dvs[i]),
            .in_side   (d2_side[i]),
            .out_valid (d2_valid[i+1]),
            .out_ready (d2_ready[i+1]),
            .out_rem   (d2_rem[i+1]),
            .out_quo   (d2_quo[i+1]),
            .out_dvs   (d2_dvs[i+1]),
            .out_side  (d2_side[i+1])
        );
    end

    // output register
    logic            m_valid_reg;
    logic [7:0]      fb_reg;
    pds_pkg::pcode_t code_reg;
    logic            ext_reg;
    logic [15:0]     act_reg;
    logic            clip_reg;
    logic            out_en;
    pds_pkg::side2_t fin;

    assign fin              = d2_side[ND2];
    assign out_en           = !m_valid_reg || m_ready;
    assign d2_ready[ND2]    = out_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_en) begin
            m_valid_reg <= d2_valid[ND2];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            fb_reg   <= fin.n;
            code_reg <= fin.sel.code;
            ext_reg  <= fin.sel.ext;
            clip_reg <= fin.sel.clipped;
            act_reg  <= fin.sat ? '1 : d2_quo[ND2];
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_feedback_divider = fb_reg;
    assign m_post_div_code    = code_reg;
    assign m_external_div     = ext_reg;
    assign m_actual_freq      = act_reg;
    assign m_ratio_clipped    = clip_reg;

    a_clip_n: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ratio_clipped |-> m_feedback_divider == 8'hFF)
        else $error("clipped ratio without N at maximum");

    a_clip_div1: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ratio_clipped |->
            m_post_div_code == pds_pkg::PCODE_DIV1 && !m_external_div)
        else $error("clipped ratio without plain divide by one");

    a_ext_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_external_div |-> m_post_div_code != pds_pkg::PCODE_DIV2)
        else $error("external divide paired with divide by two");

    a_zero_n: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_feedback_divider == 8'h00 |-> m_actual_freq == 16'h0000)
        else $error("zero N gave nonzero frequency");

endmodule

/* sim/pll_divider_check.sv */
// Result checker for the PLL divider select unit: predicts each item's result and compares.
`timescale 1ns / 1ps
module pll_divider_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [15:0] s_target_freq,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_feedback_divider,
    input  logic [1:0]  m_post_div_code,
    input  logic        m_external_div,
    input  logic [15:0] m_actual_freq,
    input  logic        m_ratio_clipped,
    output int          mismatch_count,
    output int          results_pending
);

    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [7:0]       fb_div;
        pds_pkg::pcode_t  code;
        logic             ext;
        logic [15:0]      actual;
        logic             clipped;
    } divider_setting_t;

    logic [15:0] min_freq_r;
    logic [15:0] max_freq_r;
    logic [15:0] ref_freq_r;
    logic [15:0] ref_div_r;

    divider_setting_t expected_settings[$];
    divider_setting_t want;
    int result_index = 0;

    initial begin
        mismatch_count  = 0;
        results_pending = 0;
    end

    function automatic divider_setting_t predict_dividers(input logic [15:0] target);
        longint unsigned f, rf, rd, num, den, n, pd, act;
        longint unsigned band_x8, band_pd;
        pds_pkg::pcode_t band_code;
        logic band_ext;
        bit found;
        divider_setting_t r;

        f  = target;
        rf = (ref_freq_r == 16'd0) ? 1 : ref_freq_r;
        rd = (ref_div_r == 16'd0) ? 1 : ref_div_r;
        // raise to min first, then lower to max: max wins when min > max
        if (f < min_freq_r) f = min_freq_r;
        if (f > max_freq_r) f = max_freq_r;

        // ratio Q = num / den, thresholds compared at 8x to stay integral
        num = f * rd;
        den = 2 * rf;
        r.clipped = 1'b0;
        r.code    = pds_pkg::PCODE_DIV8;
        r.ext     = 1'b1;
        pd        = 12;
        found     = 1'b0;

        if (num * 8 > 2040 * den) begin
            r.clipped = 1'b1;
            r.code    = pds_pkg::PCODE_DIV1;
            r.ext     = 1'b0;
            pd        = 1;
            n         = 255;
        end else begin
            for (int k = 1; k < 7; k++) begin
                case (k)
                    1: begin
                        band_x8 = 1020; band_pd = 1;
                        band_code = pds_pkg::PCODE_DIV1; band_ext = 1'b0;
                    end
                    2: begin
                        band_x8 = 680; band_pd = 2;
                        band_code = pds_pkg::PCODE_DIV2; band_ext = 1'b0;
                    end
                    3: begin
                        band_x8 = 510; band_pd = 3;
                        band_code = pds_pkg::PCODE_DIV1; band_ext = 1'b1;
                    end
                    4: begin
                        band_x8 = 340; band_pd = 4;
                        band_code = pds_pkg::PCODE_DIV4; band_ext = 1'b0;
                    end
                    5: begin
                        band_x8 = 255; band_pd = 6;
                        band_code = pds_pkg::PCODE_DIV4; band_ext = 1'b1;
                    end
                    default: begin
                        band_x8 = 170; band_pd = 8;
                        band_code = pds_pkg::PCODE_DIV8; band_ext = 1'b0;
                    end
                endcase
                if (!found && num * 8 > band_x8 * den) begin
                    found  = 1'b1;
                    pd     = band_pd;
                    r.code = band_code;
                    r.ext  = band_ext;
                end
            end
            // round half up
            n = (2 * num * pd + den) / (2 * den);
            if (n > 255) n = 255;
        end

        act = (2 * rf * n) / (rd * pd);
        if (act > 65535) act = 65535;

        r.fb_div = n[7:0];
        r.actual = act[15:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned exp_val);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t ns: result %0d %s: got %0d, expected %0d",
                     $time, result_index, what, got, exp_val);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            min_freq_r = 16'd0;
            max_freq_r = 16'hFFFF;
            ref_freq_r = 16'd1432;
            ref_div_r  = 16'd33;
            expected_settings.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    pds_pkg::REG_MIN_FREQ:    min_freq_r = cfg_wdata;
                    pds_pkg::REG_MAX_FREQ:    max_freq_r = cfg_wdata;
                    pds_pkg::REG_REF_FREQ:    ref_freq_r = cfg_wdata;
                    pds_pkg::REG_REF_DIVIDER: ref_div_r  = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_settings.push_back(predict_dividers(s_target_freq));
            if (m_valid && m_ready) begin
                if (expected_settings.size() == 0) begin
                    report_mismatch("unexpected item", m_feedback_divider, 0);
                end else begin
                    want = expected_settings.pop_front();
                    if (m_feedback_divider !== want.fb_div)
                        report_mismatch("feedback_divider", m_feedback_divider, want.fb_div);
                    if (m_post_div_code !== want.code)
                        report_mismatch("post_div_code", m_post_div_code, want.code);
                    if (m_external_div !== want.ext)
                        report_mismatch("external_div", m_external_div, want.ext);
                    if (m_actual_freq !== want.actual)
                        report_mismatch("actual_freq", m_actual_freq, want.actual);
                    if (m_ratio_clipped !== want.clipped)
                        report_mismatch("ratio_clipped", m_ratio_clipped, want.clipped);
                end
                result_index++;
            end
        end
        results_pending = expected_settings.size();
    end

endmodule

/* sim/testbench.sv */
// Testbench top for the PLL divider select unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 30;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 88;
    localparam int HOLD_AFTER   = 150;
    localparam int HOLD_CYCLES  = 250;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_target_freq;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_feedback_divider;
    logic [1:0]  m_post_div_code;
    logic        m_external_div;
    logic [15:0] m_actual_freq;
    logic        m_ratio_clipped;

    int mismatch_count;
    int results_pending;
    int results_seen;
    int cycle_count;
    bit sender_eager;
    bit receiver_eager;

    // stimulus-side copy of the settings, used only to aim targets at band edges and clamp limits
    logic [15:0] cur_min, cur_max, cur_rf, cur_rd;

    always #5 aclk = ~aclk;

    pll_divider_select_unit dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_target_freq      (s_target_freq),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_feedback_divider (m_feedback_divider),
        .m_post_div_code    (m_post_div_code),
        .m_external_div     (m_external_div),
        .m_actual_freq      (m_actual_freq),
        .m_ratio_clipped    (m_ratio_clipped)
    );

    pll_divider_check u_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_target_freq      (s_target_freq),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_feedback_divider (m_feedback_divider),
        .m_post_div_code    (m_post_div_code),
        .m_external_div     (m_external_div),
        .m_actual_freq      (m_actual_freq),
        .m_ratio_clipped    (m_ratio_clipped),
        .mismatch_count     (mismatch_count),
        .results_pending    (results_pending)
    );

    // called at a falling edge; writes all four registers back to back
    task automatic set_config(input logic [15:0] lo, input logic [15:0] hi,
                              input logic [15:0] rf, input logic [15:0] rd);
        cfg_we    <= 1'b1;
        cfg_addr  <= pds_pkg::REG_MIN_FREQ;
        cfg_wdata <= lo;
        @(negedge aclk);
        cfg_addr  <= pds_pkg::REG_MAX_FREQ;
        cfg_wdata <= hi;
        @(negedge aclk);
        cfg_addr  <= pds_pkg::REG_REF_FREQ;
        cfg_wdata <= rf;
        @(negedge aclk);
        cfg_addr  <= pds_pkg::REG_REF_DIVIDER;
        cfg_wdata <= rd;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        cur_min = lo;
        cur_max = hi;
        cur_rf  = rf;
        cur_rd  = rd;
    endtask

    task automatic random_config();
        logic [15:0] lo, hi, rf, rd;
        longint unsigned spread;
        case ($urandom_range(0, 4))
            0: lo = 16'd0;
            1: lo = 16'hFFFF;
            2: lo = 16'($urandom_range(0, 65535));
            default: lo = 16'($urandom_range(0, 3000));
        endcase
        case ($urandom_range(0, 4))
            0: hi = 16'hFFFF;
            1: hi = 16'd0;
            2: hi = 16'($urandom_range(0, 65535));
            default: hi = 16'hFFFF - 16'($urandom_range(0, 3000));
        endcase
        case ($urandom_range(0, 5))
            0: rf = 16'd0;
            1: rf = 16'hFFFF;
            default: rf = 16'($urandom_range(1, 65535));
        endcase
        if ($urandom_range(0, 1) == 0) begin
            // divider scaled so that the full target range sweeps Q over the lower bands or all of them
            spread = (longint'(rf) * $urandom_range(1, 40)) / 4096;
            rd = (spread == 0) ? 16'd1 : ((spread > 65535) ? 16'hFFFF : spread[15:0]);
        end else begin
            case ($urandom_range(0, 5))
                0: rd = 16'd0;
                1: rd = 16'hFFFF;
                default: rd = 16'($urandom_range(1, 65535));
            endcase
        end
        set_config(lo, hi, rf, rd);
    endtask

    // Mix of full-range targets, targets near the clamp limits and targets near band edges.
    function automatic logic [15:0] pick_target();
        longint signed f, rf, rd, band_x8;
        int jitter;
        int sel;
        sel    = $urandom_range(0, 99);
        jitter = int'($urandom_range(0, 8)) - 4;
        rf     = (cur_rf == 16'd0) ? 1 : cur_rf;
        rd     = (cur_rd == 16'd0) ? 1 : cur_rd;
        if (sel < 40) begin
            f = $urandom_range(0, 65535);
        end else if (sel < 50) begin
            f = longint'(($urandom_range(0, 1) == 0) ? cur_min : cur_max) + jitter;
        end else begin
            case ($urandom_range(0, 6))
                0: band_x8 = 2040;
                1: band_x8 = 1020;
                2: band_x8 = 680;
                3: band_x8 = 510;
                4: band_x8 = 340;
                5: band_x8 = 255;
                default: band_x8 = 170;
            endcase
            f = (band_x8 * rf) / (4 * rd) + jitter;
        end
        if (f < 0) f = 0;
        if (f > 65535) f = 65535;
        return f[15:0];
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_target(input logic [15:0] target);
        int gap;
        if ($urandom_range(0, 39) == 0) sender_eager = !sender_eager;
        gap = sender_eager ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_target_freq <= target;
        @(posedge aclk);
        while (!(s_valid && s_ready)) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (results_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = pds_pkg::REG_MIN_FREQ;
        cfg_wdata     = 16'd0;
        s_valid       = 1'b0;
        s_target_freq = 16'd0;
        sender_eager  = 1'b0;
        cur_min       = 16'd0;
        cur_max       = 16'hFFFF;
        cur_rf        = 16'd1432;
        cur_rd        = 16'd33;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // register defaults: zero target gives N of zero, plus full-scale and bit patterns
        send_target(16'd0);
        send_target(16'd1);
        send_target(16'hFFFF);
        send_target(16'h8000);
        send_target(16'hAAAA);
        send_target(16'h5555);
        drain();

        // Q = target / 16: each band edge stays in the lower band, one above moves up
        set_config(16'd0, 16'hFFFF, 16'd8, 16'd1);
        send_target(16'd4080); send_target(16'd4081);
        send_target(16'd2040); send_target(16'd2041);
        send_target(16'd1360); send_target(16'd1361);
        send_target(16'd1020); send_target(16'd1021);
        send_target(16'd680);  send_target(16'd681);
        send_target(16'd510);  send_target(16'd511);
        send_target(16'd340);  send_target(16'd341);
        drain();

        // minimum above maximum: everything lands on the maximum
        set_config(16'hFFFF, 16'd1000, 16'd1432, 16'd33);
        send_target(16'd0);
        send_target(16'hFFFF);
        drain();

        // zero reference frequency and zero divider act as one
        set_config(16'd0, 16'hFFFF, 16'd0, 16'd0);
        send_target(16'd100);
        send_target(16'd600);
        drain();

        // rounding N up pushes the achieved frequency past full scale
        set_config(16'd0, 16'hFFFF, 16'd60000, 16'd1);
        send_target(16'hFFFF);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_config(16'd0, 16'hFFFF, 16'd1432, 16'd33);
                1: set_config(16'd0, 16'hFFFF, 16'd1, 16'hFFFF);
                2: set_config(16'd0, 16'hFFFF, 16'hFFFF, 16'd1);
                default: random_config();
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) send_target(pick_target());
            drain();
        end

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // result side; one long hold-off lets the pipeline fill and back up the input
    initial begin
        int wait_cycles;
        m_ready        = 1'b0;
        results_seen   = 0;
        receiver_eager = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) receiver_eager = !receiver_eager;
            if (results_seen == HOLD_AFTER)
                wait_cycles = HOLD_CYCLES;
            else
                wait_cycles = receiver_eager ? 0 : $urandom_range(0, 13);
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
            results_seen++;
            @(negedge aclk);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

endmodule
